>>> design/pfsp_pkg.sv
// Package with the types, codes and helpers of the printf format specification parser.
package pfsp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned STAR_W  = 32;
   localparam int unsigned VALUE_W = 31;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 96;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_H       = 8'h68;
   localparam logic [CHAR_W-1:0] CH_L       = 8'h6C;
   localparam logic [CHAR_W-1:0] CH_C       = 8'h63;
   localparam logic [CHAR_W-1:0] CH_S       = 8'h73;
   localparam logic [CHAR_W-1:0] CH_P       = 8'h70;
   localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
   localparam logic [CHAR_W-1:0] CH_I       = 8'h69;
   localparam logic [CHAR_W-1:0] CH_U       = 8'h75;
   localparam logic [CHAR_W-1:0] CH_X_LOW   = 8'h78;
   localparam logic [CHAR_W-1:0] CH_X_UP    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_N       = 8'h6E;
   localparam logic [CHAR_W-1:0] CH_F       = 8'h66;
   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;

   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_SPACE = 2'd2;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_H    = 3'd1;
   localparam logic [2:0] LEN_HH   = 3'd2;
   localparam logic [2:0] LEN_L    = 3'd3;
   localparam logic [2:0] LEN_LL   = 3'd4;

   localparam logic [3:0] CONV_NONE    = 4'd0;
   localparam logic [3:0] CONV_C       = 4'd1;
   localparam logic [3:0] CONV_S       = 4'd2;
   localparam logic [3:0] CONV_P       = 4'd3;
   localparam logic [3:0] CONV_D       = 4'd4;
   localparam logic [3:0] CONV_I       = 4'd5;
   localparam logic [3:0] CONV_U       = 4'd6;
   localparam logic [3:0] CONV_X_LOW   = 4'd7;
   localparam logic [3:0] CONV_X_UP    = 4'd8;
   localparam logic [3:0] CONV_N       = 4'd9;
   localparam logic [3:0] CONV_F       = 4'd10;
   localparam logic [3:0] CONV_PERCENT = 4'd11;

   typedef enum logic [5:0] {
      PH_FLAGS  = 6'b000001,
      PH_WIDTH  = 6'b000010,
      PH_POINT  = 6'b000100,
      PH_PREC   = 6'b001000,
      PH_LENGTH = 6'b010000,
      PH_END    = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic               left_justify;
      logic               fill_zero;
      logic [1:0]         sign_mode;
      logic               alt_form;
      logic [VALUE_W-1:0] width;
      logic               point;
      logic [VALUE_W-1:0] precision;
      logic [2:0]         length;
      logic [3:0]         conversion;
      logic [COUNT_W-1:0] count;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_FLAGS,
      left_justify: 1'b0,
      fill_zero:    1'b0,
      sign_mode:    SIGN_NONE,
      alt_form:     1'b0,
      width:        '0,
      point:        1'b0,
      precision:    '0,
      length:       LEN_NONE,
      conversion:   CONV_NONE,
      count:        '0
   };

   // Multiplies by ten with two shifts and adds the digit, saturating at the largest value.
   function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] acc,
                                                   input logic [3:0] digit);
      logic [VALUE_W+3:0] sum;
      sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_W+4)'(digit);
      if (sum > (VALUE_W+4)'(VALUE_MAX)) begin
         return VALUE_MAX;
      end
      return sum[VALUE_W-1:0];
   endfunction

   function automatic logic [3:0] conv_code(input logic [CHAR_W-1:0] ch);
      case (ch)
         CH_C:       return CONV_C;
         CH_S:       return CONV_S;
         CH_P:       return CONV_P;
         CH_D:       return CONV_D;
         CH_I:       return CONV_I;
         CH_U:       return CONV_U;
         CH_X_LOW:   return CONV_X_LOW;
         CH_X_UP:    return CONV_X_UP;
         CH_N:       return CONV_N;
         CH_F:       return CONV_F;
         CH_PERCENT: return CONV_PERCENT;
         default:    return CONV_NONE;
      endcase
   endfunction

endpackage

>>> design/pfsp_step.sv
// Next-state logic that applies one specification character to the parse state.
module pfsp_step (
   input  pfsp_pkg::state_type                 state_in,
   input  logic [pfsp_pkg::CHAR_W-1:0]         character,
   input  logic [pfsp_pkg::STAR_W-1:0]         star_value,
   input  logic                                first_of_spec,
   output pfsp_pkg::state_type                 state_out,
   output logic                                consumed
);
   import pfsp_pkg::*;

   state_type          cur;
   state_type          nxt;
   logic               took;
   logic               neg;
   logic [STAR_W-1:0]  magnitude;
   logic [VALUE_W-1:0] neg_width;
   logic               is_digit;
   logic               is_flag;
   logic [3:0]         conv;
   logic [VALUE_W-1:0] width_acc;
   logic [VALUE_W-1:0] prec_acc;
   logic               up_to_width;
   logic               up_to_point;
   logic               in_precision;

   always_comb begin
      cur          = first_of_spec ? STATE_RESET : state_in;
      neg          = star_value[STAR_W-1];
      magnitude    = ~star_value + STAR_W'(1);
      neg_width    = magnitude[STAR_W-1] ? VALUE_MAX : magnitude[VALUE_W-1:0];
      is_digit     = (character >= CH_ZERO) && (character <= CH_NINE);
      is_flag      = (character == CH_MINUS) || (character == CH_ZERO) ||
                     (character == CH_PLUS) || (character == CH_SPACE) ||
                     (character == CH_HASH);
      conv         = conv_code(character);
      width_acc    = add_digit(cur.width, character[3:0]);
      prec_acc     = add_digit(cur.precision, character[3:0]);
      up_to_width  = (cur.phase == PH_FLAGS) || (cur.phase == PH_WIDTH);
      up_to_point  = up_to_width || (cur.phase == PH_POINT);
      in_precision = (cur.phase == PH_POINT) || (cur.phase == PH_PREC);
      nxt          = cur;
      took         = 1'b0;

      if (cur.phase == PH_END) begin
         nxt.phase = PH_END;
      end else if ((cur.phase == PH_FLAGS) && is_flag) begin
         took = 1'b1;
         if (character == CH_MINUS) begin
            nxt.left_justify = 1'b1;
            nxt.fill_zero    = 1'b0;
         end
         if ((character == CH_ZERO) && !cur.left_justify) begin
            nxt.fill_zero = 1'b1;
         end
         if (character == CH_PLUS) begin
            nxt.sign_mode = SIGN_PLUS;
         end
         if ((character == CH_SPACE) && (cur.sign_mode == SIGN_NONE)) begin
            nxt.sign_mode = SIGN_SPACE;
         end
         if (character == CH_HASH) begin
            nxt.alt_form = 1'b1;
         end
      end else if ((cur.phase == PH_FLAGS) && (character == CH_STAR)) begin
         took = 1'b1;
         nxt.phase = PH_WIDTH;
         if (neg) begin
            nxt.width        = neg_width;
            nxt.left_justify = 1'b1;
            nxt.fill_zero    = 1'b0;
         end else begin
            nxt.width = star_value[VALUE_W-1:0];
         end
      end else if (up_to_width && is_digit) begin
         took = 1'b1;
         nxt.width = width_acc;
         nxt.phase = PH_WIDTH;
      end else if (up_to_width && (character == CH_POINT)) begin
         took = 1'b1;
         nxt.point = 1'b1;
         nxt.phase = PH_POINT;
      end else if (up_to_point && (character == CH_STAR)) begin
         took = 1'b1;
         nxt.phase = PH_PREC;
         if (neg) begin
            nxt.point     = 1'b0;
            nxt.precision = '0;
         end else begin
            nxt.precision = star_value[VALUE_W-1:0];
         end
      end else if (in_precision && is_digit) begin
         took = 1'b1;
         nxt.precision = prec_acc;
         nxt.phase     = PH_PREC;
      end else if ((character == CH_H) || (character == CH_L)) begin
         took = 1'b1;
         nxt.phase = PH_LENGTH;
         if (character == CH_L) begin
            if (cur.length == LEN_L) begin
               nxt.length = LEN_LL;
            end else if (cur.length == LEN_NONE) begin
               nxt.length = LEN_L;
            end
         end else begin
            if (cur.length == LEN_H) begin
               nxt.length = LEN_HH;
            end else if (cur.length == LEN_NONE) begin
               nxt.length = LEN_H;
            end
         end
      end else if (conv != CONV_NONE) begin
         took = 1'b1;
         nxt.conversion = conv;
         nxt.phase      = PH_END;
      end else begin
         nxt.phase = PH_END;
      end

      if (took && (cur.count != COUNT_MAX)) begin
         nxt.count = cur.count + COUNT_W'(1);
      end
   end

   assign state_out = nxt;
   assign consumed  = took;

endmodule

>>> design/printf_format_spec_parser_core.sv
// Top level of the printf format specification parser with its stream ports.
//
//   Channel   Direction   Contents of one item
//   req_*     in          one character of the specification and its star argument
//   rsp_*     out         the parse state after that character
//
// Every item passes an input register and then a result register, where its result is
// offered; one item is taken in every cycle while no result is stalled.
// A digit updates the state by one multiply-by-ten accumulate with saturation.
// The synchronous reset clears the parse state and empties both registers.
// A stalled result holds the input register; a new item is still taken while a
// result waits if the input register is empty.
module printf_format_spec_parser_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // character [7:0], star_value [39:8]
   input  logic [pfsp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // first_of_spec [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // consumed [0], done_res [1], left_justify [2], fill_zero [3], sign_mode [5:4],
   // alt_form [6], field_width [37:7], has_point [38], precision_value [69:39],
   // length_mod [72:70], conversion [76:73], char_count [92:77], zero fill [95:93]
   output logic [pfsp_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import pfsp_pkg::*;

   logic                  in_valid_ff;
   logic [CHAR_W-1:0]     char_ff;
   logic [STAR_W-1:0]     star_ff;
   logic                  first_ff;
   state_type             state_ff;
   state_type             state_in;
   logic                  consumed;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  advance;
   logic                  req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   pfsp_step u_step (
      .state_in      (state_ff),
      .character     (char_ff),
      .star_value    (star_ff),
      .first_of_spec (first_ff),
      .state_out     (state_in),
      .consumed      (consumed)
   );

   assign rsp_data_in = {
      3'b000,
      state_in.count,
      state_in.conversion,
      state_in.length,
      state_in.precision,
      state_in.point,
      state_in.width,
      state_in.alt_form,
      state_in.sign_mode,
      state_in.fill_zero,
      state_in.left_justify,
      (state_in.phase == PH_END),
      consumed
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff  <= req_tdata[CHAR_W-1:0];
         star_ff  <= req_tdata[CHAR_W+STAR_W-1:CHAR_W];
         first_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("Result register not empty after reset.");

   a_conv_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase != PH_END) |-> (state_ff.conversion == CONV_NONE))
      else $error("Conversion recorded before the specification ended.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && !first_ff |=>
      (state_ff.count == $past(state_ff.count)) ||
      (state_ff.count == $past(state_ff.count) + COUNT_W'(1)))
      else $error("Character count moved by more than one.");

   a_consumed_end: assert property (@(posedge clock) disable iff (reset)
      advance && consumed && (state_in.phase == PH_END) |->
      (state_in.conversion != CONV_NONE))
      else $error("Specification ended on a consumed character without a conversion.");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(state_ff))
      else $error("Parse state changed while a result was stalled.");
`endif

endmodule
